// ----- hdl/lca_pkg.sv -----
package lca_pkg;

    localparam int UNIT_COUNT    = 2048;
    localparam int LARGE_CLASSES = 36;
    localparam int UNIT_W        = 11;
    localparam int HEAD_AW       = 6;
    localparam int RANK_W        = 7;

    localparam logic [RANK_W-1:0] FIRST_LARGE = 7'd40;
    localparam logic [RANK_W-1:0] STEP_END    = 7'd64;
    localparam logic [RANK_W-1:0] ALL_RANKS   = 7'd76;
    localparam logic [7:0]        TAG_BASE    = 8'd128;
    localparam logic [7:0]        RANK_LIMIT  = 8'd31;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_NOSPACE  = 3'd1,
        STAT_NOTLARGE = 3'd2,
        STAT_BAD      = 3'd3,
        STAT_BLOCK    = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        ST_CLR, ST_INIT, ST_IDLE, ST_DECODE,
        ST_SRCH_RD, ST_SRCH_CK, ST_POP1, ST_POP2, ST_POP3,
        ST_SPL_NEXT, ST_MK0, ST_MK1, ST_MK2, ST_TAG,
        ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_DONE
    } state_t;

    typedef struct packed {
        logic                map_we;
        logic [UNIT_W-1:0]   map_waddr;
        logic [7:0]          map_wdata;
        logic [UNIT_W-1:0]   map_raddr;
        logic                hd_we;
        logic [HEAD_AW-1:0]  hd_waddr;
        logic [UNIT_W-1:0]   hd_wdata;
        logic [HEAD_AW-1:0]  hd_raddr;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]        cnt;
        logic [RANK_W-1:0] first;
        logic [RANK_W-1:0] second;
    } tail_t;

    function automatic logic [UNIT_W-1:0] units_of(input logic [RANK_W-1:0] rank);
        logic [4:0]  e;
        logic [11:0] u;
        e = rank[6:2];
        if (e < 5'd10 || e > 5'd19)
            u = 12'd1;
        else
            u = {9'd0, 1'b1, rank[1:0]} << (e - 5'd10);
        return u[UNIT_W-1:0];
    endfunction

    function automatic logic [RANK_W-1:0] sat_rank(input logic [7:0] rank);
        return (rank > {1'b0, ALL_RANKS}) ? ALL_RANKS : rank[RANK_W-1:0];
    endfunction

    function automatic logic [HEAD_AW-1:0] head_idx(input logic [RANK_W-1:0] rank);
        logic [RANK_W-1:0] k;
        k = rank - FIRST_LARGE;
        return k[HEAD_AW-1:0];
    endfunction

    // surplus left after the stepping phase of a split
    function automatic tail_t split_tail(input logic [RANK_W-1:0] orig,
                                         input logic [RANK_W-1:0] r);
        tail_t             t;
        logic [RANK_W-1:0] d;
        logic [1:0]        m;
        t = '0;
        d = orig - r;
        m = r[1:0];
        if (orig > r) begin
            t.cnt = 2'd1;
            case (d)
                7'd1: t.first = {r[6:2], 2'b00} - 7'd8;
                7'd2: t.first = (m == 2'd0) ? r - 7'd4 : ((m == 2'd2) ? r - 7'd6 : r - 7'd5);
                7'd3: t.first = (m == 2'd1) ? r - 7'd3 : r - 7'd2;
                7'd4: t.first = r;
                7'd5:
                    if (m == 2'd3) begin
                        t.cnt = 2'd2; t.first = r - 7'd3; t.second = r - 7'd2;
                    end else t.first = r + 7'd2;
                7'd6:
                    if (m == 2'd0) t.first = r + 7'd4;
                    else if (m == 2'd1) begin
                        t.cnt = 2'd2; t.first = r - 7'd1; t.second = r;
                    end else if (m == 2'd2) t.first = r + 7'd3;
                    else begin
                        t.cnt = 2'd2; t.first = r - 7'd2; t.second = r + 7'd1;
                    end
                7'd7:
                    if (m == 2'd1) begin
                        t.cnt = 2'd2; t.first = r - 7'd1; t.second = r + 7'd2;
                    end else if (m == 2'd3) begin
                        t.cnt = 2'd2; t.first = r - 7'd2; t.second = r + 7'd3;
                    end else t.first = r + 7'd5;
                7'd8:
                    if (m == 2'd0) t.first = r + 7'd6;
                    else if (m == 2'd3) begin
                        t.cnt = 2'd2; t.first = r - 7'd2; t.second = r + 7'd5;
                    end else begin
                        t.cnt = 2'd2; t.first = r + 7'd2; t.second = r + 7'd3;
                    end
                7'd9:
                    if (r == ALL_RANKS - 7'd12) t.first = ALL_RANKS - 7'd4;
                    else if (r == ALL_RANKS - 7'd11) begin
                        t.cnt = 2'd2; t.first = ALL_RANKS - 7'd9; t.second = ALL_RANKS - 7'd6;
                    end else if (r == ALL_RANKS - 7'd10) begin
                        t.cnt = 2'd2; t.first = ALL_RANKS - 7'd8; t.second = ALL_RANKS - 7'd5;
                    end else begin
                        t.cnt = 2'd2; t.first = ALL_RANKS - 7'd11; t.second = ALL_RANKS - 7'd3;
                    end
                7'd10:
                    if (r == ALL_RANKS - 7'd12) t.first = ALL_RANKS - 7'd3;
                    else if (r == ALL_RANKS - 7'd11) begin
                        t.cnt = 2'd2; t.first = ALL_RANKS - 7'd9; t.second = ALL_RANKS - 7'd4;
                    end else begin
                        t.cnt = 2'd2; t.first = ALL_RANKS - 7'd7; t.second = ALL_RANKS - 7'd4;
                    end
                7'd11:
                    if (r == ALL_RANKS - 7'd12) t.first = ALL_RANKS - 7'd2;
                    else begin
                        t.cnt = 2'd2; t.first = ALL_RANKS - 7'd9; t.second = ALL_RANKS - 7'd3;
                    end
                7'd12: t.first = ALL_RANKS - 7'd1;
                default: t.cnt = 2'd0;
            endcase
        end
        return t;
    endfunction

endpackage

// ----- hdl/lca_rank.sv -----
module lca_rank (
    input  logic                          clk,
    input  logic                          load,
    input  logic [21:0]                   size,
    output logic [7:0]                    rank
);

    logic [7:0]  rank_reg;
    logic [7:0]  rank_next;
    logic [21:0] s;
    logic [4:0]  msb;
    logic [21:0] top;

    always_comb
    begin
        s   = size - 22'd1;
        msb = 5'd0;
        for (int i = 1; i < 22; i++)
        begin
            if (s[i])
                msb = 5'(i);
        end
        top = s >> (msb - 5'd2);
        if (size <= 22'd4)
            rank_next = 8'd0;
        else
            rank_next = {1'b0, msb, 2'b00} + {6'd0, top[1:0]} + 8'd4 - 8'd11;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rank_reg <= rank_next;
    end

    assign rank = rank_reg;

endmodule

// ----- hdl/lca_store.sv -----
module lca_store (
    input  logic                       clk,
    input  lca_pkg::mem_req_t          req,
    output logic [7:0]                 map_rdata,
    output logic [lca_pkg::UNIT_W-1:0] hd_rdata
);

    logic [7:0]                 map_mem [lca_pkg::UNIT_COUNT];
    logic [lca_pkg::UNIT_W-1:0] hd_mem  [lca_pkg::LARGE_CLASSES];
    logic [7:0]                 map_rdata_reg;
    logic [lca_pkg::UNIT_W-1:0] hd_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.map_we)
            map_mem[req.map_waddr] <= req.map_wdata;
        map_rdata_reg <= map_mem[req.map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req.hd_we)
            hd_mem[req.hd_waddr] <= req.hd_wdata;
        hd_rdata_reg <= hd_mem[req.hd_raddr];
    end

    assign map_rdata = map_rdata_reg;
    assign hd_rdata  = hd_rdata_reg;

endmodule

// ----- hdl/lca_ctrl.sv -----
module lca_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic                        as_block,
    input  logic [20:0]                 byte_offset,
    input  logic [7:0]                  rank,
    output lca_pkg::mem_req_t           mem,
    input  logic [7:0]                  map_rdata,
    input  logic [lca_pkg::UNIT_W-1:0]  hd_rdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output lca_pkg::status_t            status,
    output logic [lca_pkg::UNIT_W-1:0]  base_unit,
    output logic [lca_pkg::RANK_W-1:0]  size_rank
);

    lca_pkg::state_t state_reg, state_next;

    logic                        act_reg, blk_reg;
    logic [lca_pkg::UNIT_W-1:0]  unit_reg;
    logic [lca_pkg::RANK_W-1:0]  req_reg, r_reg, orig_reg, mk_rank_reg, q1_reg, q2_reg;
    logic [lca_pkg::UNIT_W-1:0]  base_reg, b_reg, mk_base_reg, h_reg, cnt_reg;
    logic [7:0]                  lo_reg, x_reg, frank_reg;
    logic                        mk_wr_reg, done_after_reg, tail_reg, init_reg;
    logic [1:0]                  t_cnt_reg;
    lca_pkg::status_t            res_st_reg, st_out_reg;
    logic [lca_pkg::UNIT_W-1:0]  res_base_reg, base_out_reg;
    logic [lca_pkg::RANK_W-1:0]  res_rank_reg, rank_out_reg;
    logic                        out_valid_reg;

    logic [lca_pkg::RANK_W-1:0]  r_adv;
    logic [lca_pkg::UNIT_W-1:0]  tag_n;
    logic                        rank_bad, x_special, split_end_idle, mark_bad;
    lca_pkg::tail_t              tail;

    always_comb
    begin
        r_adv     = (r_reg < lca_pkg::STEP_END) ? r_reg + 7'd4 : r_reg + 7'd1;
        tag_n     = blk_reg ? lca_pkg::units_of(req_reg) - 11'd1 : 11'd2;
        rank_bad  = (rank < {1'b0, lca_pkg::FIRST_LARGE}) || (rank >= {1'b0, lca_pkg::ALL_RANKS});
        x_special = (map_rdata <= lca_pkg::RANK_LIMIT) || (map_rdata >= lca_pkg::TAG_BASE);
        mark_bad  = (frank_reg < {1'b0, lca_pkg::FIRST_LARGE})
                 || (frank_reg >= {1'b0, lca_pkg::ALL_RANKS})
                 || (map_rdata != 8'd0 && map_rdata[7:6] != 2'b10);
        tail      = lca_pkg::split_tail(orig_reg, r_reg);
        split_end_idle = init_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lca_pkg::ST_CLR:
                if (cnt_reg == 11'(lca_pkg::UNIT_COUNT - 1))
                    state_next = lca_pkg::ST_INIT;
            lca_pkg::ST_INIT:
                state_next = lca_pkg::ST_SPL_NEXT;
            lca_pkg::ST_IDLE:
                if (in_valid)
                    state_next = lca_pkg::ST_DECODE;
            lca_pkg::ST_DECODE:
                if (!act_reg)
                    state_next = rank_bad ? lca_pkg::ST_DONE : lca_pkg::ST_SRCH_RD;
                else
                    state_next = (unit_reg < 11'd4) ? lca_pkg::ST_DONE : lca_pkg::ST_F1;
            lca_pkg::ST_SRCH_RD:
                state_next = lca_pkg::ST_SRCH_CK;
            lca_pkg::ST_SRCH_CK:
                if (hd_rdata != '0)
                    state_next = lca_pkg::ST_POP1;
                else if (r_adv >= lca_pkg::ALL_RANKS)
                    state_next = lca_pkg::ST_DONE;
                else
                    state_next = lca_pkg::ST_SRCH_RD;
            lca_pkg::ST_POP1:
                state_next = lca_pkg::ST_POP2;
            lca_pkg::ST_POP2:
                state_next = lca_pkg::ST_POP3;
            lca_pkg::ST_POP3:
                state_next = (orig_reg != req_reg) ? lca_pkg::ST_SPL_NEXT : lca_pkg::ST_TAG;
            lca_pkg::ST_SPL_NEXT:
                if (r_reg < lca_pkg::STEP_END)
                    state_next = lca_pkg::ST_MK0;
                else if (tail_reg && t_cnt_reg == 2'd0)
                    state_next = split_end_idle ? lca_pkg::ST_IDLE : lca_pkg::ST_TAG;
                else if (tail_reg)
                    state_next = lca_pkg::ST_MK0;
            lca_pkg::ST_MK0:
                state_next = lca_pkg::ST_MK1;
            lca_pkg::ST_MK1:
                state_next = lca_pkg::ST_MK2;
            lca_pkg::ST_MK2:
                if (!mk_wr_reg)
                    state_next = lca_pkg::ST_DONE;
                else if (done_after_reg)
                    state_next = split_end_idle ? lca_pkg::ST_IDLE : lca_pkg::ST_TAG;
                else
                    state_next = lca_pkg::ST_SPL_NEXT;
            lca_pkg::ST_TAG:
                if (cnt_reg == tag_n - 11'd1)
                    state_next = lca_pkg::ST_DONE;
            lca_pkg::ST_F1:
                state_next = x_special ? lca_pkg::ST_F2 : lca_pkg::ST_F3;
            lca_pkg::ST_F2:
                if (x_reg <= lca_pkg::RANK_LIMIT && map_rdata < lca_pkg::TAG_BASE)
                    state_next = lca_pkg::ST_DONE;
                else
                    state_next = lca_pkg::ST_F3;
            lca_pkg::ST_F3:
                state_next = lca_pkg::ST_F4;
            lca_pkg::ST_F4:
                state_next = lca_pkg::ST_F5;
            lca_pkg::ST_F5:
                state_next = (mark_bad || map_rdata != 8'd0) ? lca_pkg::ST_DONE
                                                              : lca_pkg::ST_MK0;
            lca_pkg::ST_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = lca_pkg::ST_IDLE;
            default:
                state_next = lca_pkg::ST_IDLE;
        endcase
    end

    // memory controls
    always_comb
    begin
        mem = '0;
        unique case (state_reg)
            lca_pkg::ST_CLR:
            begin
                mem.map_we    = 1'b1;
                mem.map_waddr = cnt_reg;
                if (cnt_reg < 11'(lca_pkg::LARGE_CLASSES))
                begin
                    mem.hd_we    = 1'b1;
                    mem.hd_waddr = cnt_reg[lca_pkg::HEAD_AW-1:0];
                end
            end
            lca_pkg::ST_INIT:
            begin
                mem.map_we    = 1'b1;
                mem.map_wdata = {1'b0, lca_pkg::FIRST_LARGE};
            end
            lca_pkg::ST_DECODE:
                mem.map_raddr = unit_reg;
            lca_pkg::ST_F1:
                mem.map_raddr = unit_reg - 11'd1;
            lca_pkg::ST_F3:
                mem.map_raddr = base_reg;
            lca_pkg::ST_F4:
                mem.map_raddr = base_reg + 11'd1;
            lca_pkg::ST_SRCH_RD:
                mem.hd_raddr = lca_pkg::head_idx(r_reg);
            lca_pkg::ST_POP1:
                mem.map_raddr = base_reg + 11'd1;
            lca_pkg::ST_POP2:
                mem.map_raddr = base_reg + 11'd2;
            lca_pkg::ST_POP3:
            begin
                mem.hd_we    = 1'b1;
                mem.hd_waddr = lca_pkg::head_idx(orig_reg);
                mem.hd_wdata = {map_rdata[4:0], lo_reg[5:0]};
                mem.map_we    = (orig_reg != req_reg);
                mem.map_waddr = base_reg;
                mem.map_wdata = {1'b0, req_reg};
            end
            lca_pkg::ST_MK0:
            begin
                mem.hd_raddr  = lca_pkg::head_idx(mk_rank_reg);
                mem.map_we    = mk_wr_reg;
                mem.map_waddr = mk_base_reg;
                mem.map_wdata = {1'b0, mk_rank_reg};
            end
            lca_pkg::ST_MK1:
            begin
                mem.map_we    = 1'b1;
                mem.map_waddr = mk_base_reg + 11'd1;
                mem.map_wdata = {2'b11, hd_rdata[5:0]};
            end
            lca_pkg::ST_MK2:
            begin
                mem.map_we    = 1'b1;
                mem.map_waddr = mk_base_reg + 11'd2;
                mem.map_wdata = {3'd0, h_reg[10:6]};
                mem.hd_we     = 1'b1;
                mem.hd_waddr  = lca_pkg::head_idx(mk_rank_reg);
                mem.hd_wdata  = mk_base_reg;
            end
            lca_pkg::ST_TAG:
            begin
                mem.map_we    = 1'b1;
                mem.map_waddr = base_reg + 11'd1 + cnt_reg;
                if (blk_reg)
                    mem.map_wdata = cnt_reg[0] ? {3'd0, base_reg[10:6]}
                                               : {2'b10, base_reg[5:0]};
            end
            default:
                mem = '0;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lca_pkg::ST_CLR;
            cnt_reg       <= '0;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lca_pkg::ST_CLR)
                cnt_reg <= cnt_reg + 11'd1;
            else if (state_reg == lca_pkg::ST_TAG)
                cnt_reg <= cnt_reg + 11'd1;
            else
                cnt_reg <= '0;
            if (state_reg == lca_pkg::ST_IDLE)
                init_reg <= 1'b0;
            if (state_reg == lca_pkg::ST_DONE && state_next == lca_pkg::ST_IDLE)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lca_pkg::ST_INIT:
            begin
                base_reg  <= '0;
                orig_reg  <= lca_pkg::ALL_RANKS;
                req_reg   <= lca_pkg::FIRST_LARGE;
                r_reg     <= lca_pkg::FIRST_LARGE;
                b_reg     <= lca_pkg::units_of(lca_pkg::FIRST_LARGE);
                tail_reg  <= 1'b0;
                mk_wr_reg <= 1'b1;
            end
            lca_pkg::ST_IDLE:
            begin
                act_reg  <= action;
                blk_reg  <= as_block;
                unit_reg <= byte_offset[20:10];
            end
            lca_pkg::ST_DECODE:
            begin
                r_reg        <= rank[lca_pkg::RANK_W-1:0];
                req_reg      <= rank[lca_pkg::RANK_W-1:0];
                res_base_reg <= act_reg ? unit_reg : '0;
                res_st_reg   <= act_reg ? lca_pkg::STAT_BAD : lca_pkg::STAT_NOTLARGE;
                res_rank_reg <= act_reg ? '0 : lca_pkg::sat_rank(rank);
            end
            lca_pkg::ST_SRCH_CK:
            begin
                orig_reg     <= r_reg;
                base_reg     <= hd_rdata;
                r_reg        <= r_adv;
                res_st_reg   <= lca_pkg::STAT_NOSPACE;
                res_base_reg <= '0;
                res_rank_reg <= req_reg;
            end
            lca_pkg::ST_POP2:
                lo_reg <= map_rdata;
            lca_pkg::ST_POP3:
            begin
                r_reg        <= req_reg;
                b_reg        <= base_reg + lca_pkg::units_of(req_reg);
                tail_reg     <= 1'b0;
                mk_wr_reg    <= 1'b1;
                res_st_reg   <= lca_pkg::STAT_OK;
                res_base_reg <= base_reg;
                res_rank_reg <= req_reg;
            end
            lca_pkg::ST_SPL_NEXT:
                if (r_reg < lca_pkg::STEP_END)
                begin
                    mk_rank_reg    <= r_reg;
                    mk_base_reg    <= b_reg;
                    b_reg          <= b_reg + lca_pkg::units_of(r_reg);
                    r_reg          <= r_reg + 7'd4;
                    done_after_reg <= (r_reg + 7'd4 == orig_reg);
                end
                else if (!tail_reg)
                begin
                    tail_reg  <= 1'b1;
                    t_cnt_reg <= tail.cnt;
                    q1_reg    <= tail.first;
                    q2_reg    <= tail.second;
                end
                else
                begin
                    mk_rank_reg    <= q1_reg;
                    mk_base_reg    <= b_reg;
                    b_reg          <= b_reg + lca_pkg::units_of(q1_reg);
                    q1_reg         <= q2_reg;
                    t_cnt_reg      <= t_cnt_reg - 2'd1;
                    done_after_reg <= (t_cnt_reg == 2'd1);
                end
            lca_pkg::ST_MK1:
                h_reg <= hd_rdata;
            lca_pkg::ST_F1:
            begin
                x_reg    <= map_rdata;
                base_reg <= unit_reg;
            end
            lca_pkg::ST_F2:
                if (x_reg <= lca_pkg::RANK_LIMIT)
                    base_reg <= {x_reg[4:0], map_rdata[5:0]};
                else if (map_rdata <= lca_pkg::RANK_LIMIT)
                    base_reg <= {map_rdata[4:0], x_reg[5:0]};
                else
                    base_reg <= unit_reg - 11'd1;
            lca_pkg::ST_F4:
                frank_reg <= map_rdata;
            lca_pkg::ST_F5:
            begin
                res_base_reg <= base_reg;
                res_rank_reg <= lca_pkg::sat_rank(frank_reg);
                mk_base_reg  <= base_reg;
                mk_rank_reg  <= frank_reg[lca_pkg::RANK_W-1:0];
                mk_wr_reg    <= 1'b0;
                if (mark_bad)
                    res_st_reg <= lca_pkg::STAT_BAD;
                else if (map_rdata != 8'd0)
                    res_st_reg <= lca_pkg::STAT_BLOCK;
                else
                    res_st_reg <= lca_pkg::STAT_OK;
            end
            lca_pkg::ST_DONE:
                if (!out_valid_reg || out_ready)
                begin
                    st_out_reg   <= res_st_reg;
                    base_out_reg <= res_base_reg;
                    rank_out_reg <= res_rank_reg;
                end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = (state_reg == lca_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = st_out_reg;
    assign base_unit = base_out_reg;
    assign size_rank = rank_out_reg;

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem.hd_we |-> mem.hd_waddr < 6'(lca_pkg::LARGE_CLASSES))
        else $error("free-list head write out of range");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lca_pkg::ST_DONE |-> !mem.map_we && !mem.hd_we)
        else $error("memory write while result pending");

endmodule

// ----- hdl/large_chunk_allocator_top.sv -----
// Large chunk allocator: one transaction in, one result out.
// Allocate probes the free lists in turn, pops a chunk, writes back each split piece (with a tail
// lookup past the stepped ranks) and then writes the tags (plain, or block);
// a rejected size goes straight to the result; free reads the chunk marks and relinks the chunk.
// Throughput: one transaction in flight; the next can be taken once the result is presented.
// Reset: async, active low; the unit map is cleared, then the initial layout is built.
module large_chunk_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // request_size[21:0], as_block, byte_offset[20:0]
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // base_unit[10:0], size_rank[6:0]
    output logic [2:0]  m_axis_tuser    // status
);

    lca_pkg::mem_req_t           mem;
    logic [7:0]                  map_rdata;
    logic [lca_pkg::UNIT_W-1:0]  hd_rdata;
    logic [7:0]                  rank;
    lca_pkg::status_t            status;
    logic [lca_pkg::UNIT_W-1:0]  base_unit;
    logic [lca_pkg::RANK_W-1:0]  size_rank;

    lca_rank u_rank (
        .clk  (clk),
        .load (s_axis_tvalid && s_axis_tready),
        .size (s_axis_tdata[21:0]),
        .rank (rank)
    );

    lca_store u_store (
        .clk       (clk),
        .req       (mem),
        .map_rdata (map_rdata),
        .hd_rdata  (hd_rdata)
    );

    lca_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .action      (s_axis_tuser),
        .as_block    (s_axis_tdata[22]),
        .byte_offset (s_axis_tdata[43:23]),
        .rank        (rank),
        .mem         (mem),
        .map_rdata   (map_rdata),
        .hd_rdata    (hd_rdata),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .status      (status),
        .base_unit   (base_unit),
        .size_rank   (size_rank)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = {6'd0, size_rank, base_unit};

endmodule
